FILE: sv/vtrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtrs_pkg
// Shared types and constants of the voted triple record store: record
// layout, function codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package vtrs_pkg;

   // store geometry
   localparam int STORE_BYTES_DEF = 1024;
   localparam int COPY_BYTES      = 6;
   localparam int SLOT_BYTES      = 3 * COPY_BYTES;

   // field widths
   localparam int FUNC_W = 3;
   localparam int WORD_W = 16;
   localparam int POS_W  = 10;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // special words
   localparam logic [WORD_W-1:0] ERASED_WORD   = 16'hFFFF;
   localparam logic [WORD_W-1:0] DISAGREE_WORD = 16'hFFF0;

   // register reset values
   localparam logic [WORD_W-1:0] SAVE_DELAY_RST    = 16'd1000;
   localparam logic [WORD_W-1:0] COUNTER_LIMIT_RST = 16'd50000;
   localparam logic [WORD_W-1:0] VALUE_MAX_RST     = 16'd1023;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SAVE   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SCAN   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_SAVE_DELAY    = 2'd0;
   localparam logic [1:0] CSR_COUNTER_LIMIT = 2'd1;
   localparam logic [1:0] CSR_VALUE_MAX     = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] save_delay;
      logic [WORD_W-1:0] counter_limit;
      logic [WORD_W-1:0] value_max;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } vote_type;

endpackage
`default_nettype wire

FILE: sv/vtrs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtrs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module vtrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/vtrs_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtrs_csr
// APB register bank: save delay, counter limit and value maximum.
// ----------------------------------------------------------------------------
module vtrs_csr
   import vtrs_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire [CSR_AW-1:0]  paddr,
   input  wire [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_beat;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite & pready;
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (paddr[3:2])
            CSR_SAVE_DELAY:    cfg_in.save_delay    = pwdata[WORD_W-1:0];
            CSR_COUNTER_LIMIT: cfg_in.counter_limit = pwdata[WORD_W-1:0];
            CSR_VALUE_MAX:     cfg_in.value_max     = pwdata[WORD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.save_delay    <= SAVE_DELAY_RST;
         cfg_ff.counter_limit <= COUNTER_LIMIT_RST;
         cfg_ff.value_max     <= VALUE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (paddr[3:2])
         CSR_SAVE_DELAY:    prdata = {{(CSR_DW-WORD_W){1'b0}}, cfg_ff.save_delay};
         CSR_COUNTER_LIMIT: prdata = {{(CSR_DW-WORD_W){1'b0}}, cfg_ff.counter_limit};
         CSR_VALUE_MAX:     prdata = {{(CSR_DW-WORD_W){1'b0}}, cfg_ff.value_max};
         default:           prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/vtrs_vote.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtrs_vote
// Two-out-of-three vote over the three copies of a record held in an
// eighteen-byte slot buffer (first byte in the top bits).
// ----------------------------------------------------------------------------
module vtrs_vote
   import vtrs_pkg::*;
(
   input  wire [SLOT_BYTES*8-1:0] slot,
   output vote_type               vote
);

   // bit position of the word at byte i of the slot (big-endian)
   localparam int C0_CNT = (SLOT_BYTES - 2 - 0 * COPY_BYTES - 0) * 8;
   localparam int C1_CNT = (SLOT_BYTES - 2 - 1 * COPY_BYTES - 0) * 8;
   localparam int C2_CNT = (SLOT_BYTES - 2 - 2 * COPY_BYTES - 0) * 8;
   localparam int C0_LFT = (SLOT_BYTES - 2 - 0 * COPY_BYTES - 2) * 8;
   localparam int C1_LFT = (SLOT_BYTES - 2 - 1 * COPY_BYTES - 2) * 8;
   localparam int C2_LFT = (SLOT_BYTES - 2 - 2 * COPY_BYTES - 2) * 8;
   localparam int C0_RGT = (SLOT_BYTES - 2 - 0 * COPY_BYTES - 4) * 8;
   localparam int C1_RGT = (SLOT_BYTES - 2 - 1 * COPY_BYTES - 4) * 8;
   localparam int C2_RGT = (SLOT_BYTES - 2 - 2 * COPY_BYTES - 4) * 8;

   function automatic logic [WORD_W-1:0] vote3(
      input logic [WORD_W-1:0] x,
      input logic [WORD_W-1:0] y,
      input logic [WORD_W-1:0] z
   );
      logic [WORD_W-1:0] r;
      if (x == y || x == z) begin
         r = x;
      end else if (y == z) begin
         r = y;
      end else begin
         r = DISAGREE_WORD;
      end
      return r;
   endfunction

   logic [WORD_W-1:0] cnt_raw;

   // per-word majority, erased counter reads as zero
   always_comb begin
      cnt_raw    = vote3(slot[C0_CNT +: WORD_W], slot[C1_CNT +: WORD_W],
                         slot[C2_CNT +: WORD_W]);
      vote.count = (cnt_raw == ERASED_WORD) ? '0 : cnt_raw;
      vote.left  = vote3(slot[C0_LFT +: WORD_W], slot[C1_LFT +: WORD_W],
                         slot[C2_LFT +: WORD_W]);
      vote.right = vote3(slot[C0_RGT +: WORD_W], slot[C1_RGT +: WORD_W],
                         slot[C2_RGT +: WORD_W]);
   end

endmodule
`default_nettype wire

FILE: sv/voted_triple_record_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voted_triple_record_store
// Byte store holding three copies of a counter/limits record, with voted
// reads, delayed saves and a slot scan on request.
// ----------------------------------------------------------------------------
// The store is one byte-wide RAM of STORE_BYTES bytes, accessed one byte per
// cycle, and the block works on one request beat at a time. After reset a
// clearing pass writes every byte to the erased value 0xFF; no request is
// accepted during this pass (register writes are). Tick, cancel, unknown
// codes and saves that do not write go from the accept straight to the
// result state. A read passes through the accept, the byte reads of the
// slot, a read-latency state, a vote state, an evaluation state and the
// result state. A save that writes takes the same steps, with the byte
// writes of the slot between evaluation and result. A scan reads, votes and
// evaluates each slot that it visits in turn. A request is taken while an
// earlier result still waits on the result channel; the block holds its
// next result until that one is taken.
// ----------------------------------------------------------------------------
module voted_triple_record_store
   import vtrs_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEF
) (
   input  wire               clock,
   input  wire               reset,
   // request channel
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire [31:0]        req_tdata,  // left_limit[15:0], right_limit[31:16]
   input  wire [FUNC_W-1:0]  req_tuser,  // func[2:0]
   // result channel
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [63:0]       rsp_tdata,  // saved[0], write_count[16:1],
                                         // left_value[32:17], right_value[48:33],
                                         // slot_position[58:49],
                                         // scan_overflow[59], zero[63:60]
   // configuration port
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire [CSR_AW-1:0]  csr_paddr,
   input  wire [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW     = $clog2(STORE_BYTES);
   localparam int STEP_W = $clog2(SLOT_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_RTAIL, ST_VOTE, ST_ACT, ST_WRITE, ST_EMIT
   } state_type;

   function automatic logic [WORD_W-1:0] clamp(
      input logic [WORD_W-1:0] v,
      input logic [WORD_W-1:0] vmax
   );
      return (v > vmax) ? vmax : v;
   endfunction

   cfg_type cfg;
   vote_type vote;

   // control state
   state_type         state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [2:0]        bsel_ff, bsel_in;
   logic              pending_ff, pending_in;
   logic [31:0]       time_ff, time_in;
   logic [31:0]       start_ff, start_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rsp_vld_ff, rsp_vld_in;

   // payload
   logic [FUNC_W-1:0]       op_ff, op_in;
   logic [WORD_W-1:0]       lim_l_ff, lim_l_in;
   logic [WORD_W-1:0]       lim_r_ff, lim_r_in;
   logic [SLOT_BYTES*8-1:0] rec_ff, rec_in;
   vote_type                vote_ff, vote_in;
   logic                    res_saved_ff, res_saved_in;
   logic [WORD_W-1:0]       res_count_ff, res_count_in;
   logic [WORD_W-1:0]       res_left_ff, res_left_in;
   logic [WORD_W-1:0]       res_right_ff, res_right_in;
   logic                    res_ovf_ff, res_ovf_in;
   logic [63:0]             rsp_data_ff, rsp_data_in;

   // memory port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [7:0]    rd_data;

   logic [AW:0]       slot_end;
   logic [31:0]       elapsed;
   logic [AW+POS_W-1:0] pos_ext;

   vtrs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   vtrs_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   vtrs_vote u_vote (
      .slot (rec_ff),
      .vote (vote)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // end of the next slot, for the scan bound
   assign slot_end = {1'b0, slot_ff} + (AW+1)'(2 * SLOT_BYTES);
   assign elapsed  = time_ff - start_ff;
   assign pos_ext  = {{POS_W{1'b0}}, slot_ff};

   // memory access: clearing pass and record write share the write port
   always_comb begin
      wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      wr_addr = addr_ff;
      rd_en   = (state_ff == ST_READ);
      if (state_ff == ST_CLEAR) begin
         wr_data = 8'hFF;
      end else begin
         case (bsel_ff)
            3'd0:    wr_data = res_count_ff[15:8];
            3'd1:    wr_data = res_count_ff[7:0];
            3'd2:    wr_data = lim_l_ff[15:8];
            3'd3:    wr_data = lim_l_ff[7:0];
            3'd4:    wr_data = lim_r_ff[15:8];
            3'd5:    wr_data = lim_r_ff[7:0];
            default: wr_data = 8'hFF;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      bsel_in      = bsel_ff;
      pending_in   = pending_ff;
      time_in      = time_ff;
      start_in     = start_ff;
      rd_vld_in    = (state_ff == ST_READ);
      rsp_vld_in   = rsp_vld_ff;
      op_in        = op_ff;
      lim_l_in     = lim_l_ff;
      lim_r_in     = lim_r_ff;
      rec_in       = rec_ff;
      vote_in      = vote_ff;
      res_saved_in = res_saved_ff;
      res_count_in = res_count_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_data_in  = rsp_data_ff;

      // result beat taken
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      // collect read bytes, first byte ends up in the top bits
      if (rd_vld_ff) begin
         rec_in = {rec_ff[SLOT_BYTES*8-9:0], rd_data};
      end

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(STORE_BYTES - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser;
               lim_l_in     = req_tdata[15:0];
               lim_r_in     = req_tdata[31:16];
               res_saved_in = 1'b0;
               res_count_in = '0;
               res_left_in  = '0;
               res_right_in = '0;
               res_ovf_in   = 1'b0;
               step_in      = '0;
               addr_in      = slot_ff;
               state_in     = ST_EMIT;
               case (req_tuser)
                  FUNC_TICK: begin
                     time_in = time_ff + 1'b1;
                  end
                  FUNC_SAVE: begin
                     if (!pending_ff) begin
                        pending_in = 1'b1;
                        start_in   = time_ff;
                     end else if (elapsed > {16'd0, cfg.save_delay}) begin
                        state_in = ST_READ;
                     end
                  end
                  FUNC_CANCEL: begin
                     pending_in = 1'b0;
                  end
                  FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  FUNC_SCAN: begin
                     pending_in = 1'b0;
                     start_in   = time_ff;
                     slot_in    = '0;
                     addr_in    = '0;
                     state_in   = ST_READ;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end

         ST_READ: begin
            addr_in = addr_ff + 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SLOT_BYTES - 1)) begin
               state_in = ST_RTAIL;
            end
         end

         ST_RTAIL: begin
            state_in = ST_VOTE;
         end

         ST_VOTE: begin
            vote_in  = vote;
            state_in = ST_ACT;
         end

         ST_ACT: begin
            state_in = ST_EMIT;
            case (op_ff)
               FUNC_SAVE: begin
                  res_count_in = vote_ff.count + 1'b1;
                  res_left_in  = clamp(lim_l_ff, cfg.value_max);
                  res_right_in = clamp(lim_r_ff, cfg.value_max);
                  addr_in      = slot_ff;
                  step_in      = '0;
                  bsel_in      = '0;
                  state_in     = ST_WRITE;
               end
               FUNC_READ: begin
                  res_count_in = vote_ff.count;
                  res_left_in  = clamp(vote_ff.left, cfg.value_max);
                  res_right_in = clamp(vote_ff.right, cfg.value_max);
               end
               FUNC_SCAN: begin
                  if (vote_ff.count > cfg.counter_limit) begin
                     if (slot_end > (AW+1)'(STORE_BYTES)) begin
                        res_ovf_in = 1'b1;
                     end else begin
                        slot_in  = slot_ff + AW'(SLOT_BYTES);
                        addr_in  = slot_ff + AW'(SLOT_BYTES);
                        step_in  = '0;
                        state_in = ST_READ;
                     end
                  end
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
         end

         ST_WRITE: begin
            addr_in = addr_ff + 1'b1;
            step_in = step_ff + 1'b1;
            bsel_in = (bsel_ff == 3'(COPY_BYTES - 1)) ? 3'd0 : bsel_ff + 1'b1;
            if (step_ff == STEP_W'(SLOT_BYTES - 1)) begin
               pending_in   = 1'b0;
               res_saved_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end

         ST_EMIT: begin
            // hand the result over once the output register is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {4'd0, res_ovf_ff, pos_ext[POS_W-1:0], res_right_ff,
                              res_left_ff, res_count_ff, res_saved_ff};
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         addr_ff    <= '0;
         slot_ff    <= '0;
         step_ff    <= '0;
         bsel_ff    <= '0;
         pending_ff <= 1'b0;
         time_ff    <= '0;
         start_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         slot_ff    <= slot_in;
         step_ff    <= step_in;
         bsel_ff    <= bsel_in;
         pending_ff <= pending_in;
         time_ff    <= time_in;
         start_ff   <= start_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      op_ff        <= op_in;
      lim_l_ff     <= lim_l_in;
      lim_r_ff     <= lim_r_in;
      rec_ff       <= rec_in;
      vote_ff      <= vote_in;
      res_saved_ff <= res_saved_in;
      res_count_ff <= res_count_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
`default_nettype wire

FILE: bench/record_store_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_store_check_pkg
// Result beat layout and scoreboard for the voted triple record store bench:
// a cycle-free model of the store, its save timer and its slot scan, plus a
// queue of predicted result beats checked in order.
// ----------------------------------------------------------------------------
package record_store_check_pkg;
   import vtrs_pkg::*;

   // result beat as packed on rsp_tdata, msb first
   typedef struct packed {
      logic [3:0]        pad;
      logic              scan_overflow;
      logic [POS_W-1:0]  slot_position;
      logic [WORD_W-1:0] right_value;
      logic [WORD_W-1:0] left_value;
      logic [WORD_W-1:0] write_count;
      logic              saved;
   } record_beat_type;

   class record_vote_scoreboard;
      logic [7:0]      store_bytes [STORE_BYTES_DEF];
      int unsigned     slot_offset;
      bit              save_pending;
      logic [31:0]     time_now;
      logic [31:0]     save_start;
      cfg_type         cfg;
      record_beat_type expected_records [$];
      int unsigned     mismatches;
      int unsigned     writes_seen;
      int unsigned     reads_seen;
      int unsigned     scans_seen;
      int unsigned     overflows_seen;

      function new();
         foreach (store_bytes[i]) store_bytes[i] = 8'hFF;
         slot_offset       = 0;
         save_pending      = 1'b0;
         time_now          = '0;
         save_start        = '0;
         cfg.save_delay    = SAVE_DELAY_RST;
         cfg.counter_limit = COUNTER_LIMIT_RST;
         cfg.value_max     = VALUE_MAX_RST;
         mismatches        = 0;
         writes_seen       = 0;
         reads_seen        = 0;
         scans_seen        = 0;
         overflows_seen    = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [WORD_W-1:0] value);
         case (idx)
            CSR_SAVE_DELAY:    cfg.save_delay    = value;
            CSR_COUNTER_LIMIT: cfg.counter_limit = value;
            CSR_VALUE_MAX:     cfg.value_max     = value;
            default: ;
         endcase
      endfunction

      function logic [WORD_W-1:0] register_value(logic [1:0] idx);
         case (idx)
            CSR_SAVE_DELAY:    return cfg.save_delay;
            CSR_COUNTER_LIMIT: return cfg.counter_limit;
            CSR_VALUE_MAX:     return cfg.value_max;
            default:           return '0;
         endcase
      endfunction

      // big-endian word, bytes past the store read as erased
      function logic [WORD_W-1:0] word_at(int unsigned addr);
         logic [7:0] hi;
         logic [7:0] lo;
         hi = (addr < STORE_BYTES_DEF) ? store_bytes[addr] : 8'hFF;
         lo = (addr + 1 < STORE_BYTES_DEF) ? store_bytes[addr + 1] : 8'hFF;
         return {hi, lo};
      endfunction

      // two out of three vote over the copies of one word
      function logic [WORD_W-1:0] voted_word(int unsigned field);
         logic [WORD_W-1:0] x;
         logic [WORD_W-1:0] y;
         logic [WORD_W-1:0] z;
         x = word_at(slot_offset + field);
         y = word_at(slot_offset + field + COPY_BYTES);
         z = word_at(slot_offset + field + 2 * COPY_BYTES);
         if (x == y || x == z) return x;
         if (y == z) return y;
         return DISAGREE_WORD;
      endfunction

      function logic [WORD_W-1:0] voted_count();
         logic [WORD_W-1:0] c;
         c = voted_word(0);
         return (c == ERASED_WORD) ? '0 : c;
      endfunction

      function logic [WORD_W-1:0] clamp_value(logic [WORD_W-1:0] v);
         return (v > cfg.value_max) ? cfg.value_max : v;
      endfunction

      // work out the result beat of one accepted request beat
      function void predict_record(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] left,
                                   logic [WORD_W-1:0] right);
         record_beat_type   exp;
         logic [31:0]       elapsed;
         logic [7:0]        copy_bytes [COPY_BYTES];
         logic [WORD_W-1:0] count;
         int unsigned       b;
         exp = '0;
         case (func)
            FUNC_TICK: time_now = time_now + 32'd1;
            FUNC_SAVE: begin
               if (!save_pending) begin
                  save_pending = 1'b1;
                  save_start   = time_now;
               end
               elapsed = time_now - save_start;
               if (elapsed > {16'b0, cfg.save_delay}) begin
                  count = voted_count() + 16'd1;
                  copy_bytes = '{count[15:8], count[7:0], left[15:8], left[7:0],
                                 right[15:8], right[7:0]};
                  // raw limits go to all three copies
                  for (int k = 0; k < 3; k++) begin
                     for (int j = 0; j < COPY_BYTES; j++) begin
                        b = slot_offset + k * COPY_BYTES + j;
                        if (b < STORE_BYTES_DEF) store_bytes[b] = copy_bytes[j];
                     end
                  end
                  save_pending      = 1'b0;
                  exp.saved         = 1'b1;
                  exp.write_count   = count;
                  exp.left_value    = clamp_value(left);
                  exp.right_value   = clamp_value(right);
                  writes_seen++;
               end
            end
            FUNC_CANCEL: save_pending = 1'b0;
            FUNC_READ: begin
               exp.write_count = voted_count();
               exp.left_value  = clamp_value(voted_word(2));
               exp.right_value = clamp_value(voted_word(4));
               reads_seen++;
            end
            FUNC_SCAN: begin
               save_pending = 1'b0;
               save_start   = time_now;
               slot_offset  = 0;
               scans_seen++;
               // step over worn slots while a whole next slot still fits
               while (voted_count() > cfg.counter_limit) begin
                  if (slot_offset + 2 * SLOT_BYTES > STORE_BYTES_DEF) begin
                     exp.scan_overflow = 1'b1;
                     overflows_seen++;
                     break;
                  end
                  slot_offset += SLOT_BYTES;
               end
            end
            default: ;
         endcase
         exp.slot_position = slot_offset[POS_W-1:0];
         expected_records.push_back(exp);
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] seen);
         if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatches++;
         end
      endfunction

      // compare one result beat with the oldest prediction
      function void check_result(logic [63:0] data);
         record_beat_type got;
         record_beat_type exp;
         got = data;
         if (expected_records.size() == 0) begin
            $error("result beat 0x%h with no request waiting", data);
            mismatches++;
            return;
         end
         exp = expected_records.pop_front();
         compare_field("saved", exp.saved, got.saved);
         compare_field("write_count", exp.write_count, got.write_count);
         compare_field("left_value", exp.left_value, got.left_value);
         compare_field("right_value", exp.right_value, got.right_value);
         compare_field("slot_position", exp.slot_position, got.slot_position);
         compare_field("scan_overflow", exp.scan_overflow, got.scan_overflow);
         compare_field("pad", exp.pad, got.pad);
      endfunction
   endclass

endpackage

FILE: bench/tb_voted_triple_record_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voted_triple_record_store
// Self-checking bench for the voted triple record store. A directed opening
// covers erased reads, clamping, save timing, cancel, unknown codes and the
// slot scan; a fill pass wears out every slot until the scan hits the store
// end; random phases with changing registers mix save sequences and noise,
// with random stalls on both streams and one long result back-pressure.
// ----------------------------------------------------------------------------
module tb_voted_triple_record_store;
   import vtrs_pkg::*;
   import record_store_check_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int MAX_GAP        = 8;
   localparam int PHASE_ITEMS    = 175;
   localparam int FILL_ROUNDS    = 57;
   localparam int HOLD_AT_RESULT = 400;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 64;
   localparam int CALM_EVERY     = 48;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = FUNC_SCAN + 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = {FUNC_W{1'b1}};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;   // left_limit[15:0], right_limit[31:16]
   logic [FUNC_W-1:0] req_tuser;   // func[2:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [63:0]       rsp_tdata;   // saved[0], write_count[16:1], left_value[32:17],
                                   // right_value[48:33], slot_position[58:49],
                                   // scan_overflow[59], zero[63:60]
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   record_vote_scoreboard sb = new();

   int unsigned cycle_count  = 0;
   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   bit          req_calm     = 1'b0;
   bit          rsp_calm     = 1'b0;

   voted_triple_record_store dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off, check every beat
   initial begin
      int unsigned gap;
      bit          held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (results_seen == HOLD_AT_RESULT && !held) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_result(rsp_tdata);
         results_seen++;
         if (results_seen % CALM_EVERY == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // one request beat; starts and ends at a falling edge
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] left,
                               input logic [WORD_W-1:0] right);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = func;
      req_tdata  = {right, left};
      req_tvalid = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.predict_record(func, left, right);
      items_sent++;
      if (items_sent % CALM_EVERY == 0) req_calm = ($urandom_range(0, 3) == 0);
      @(negedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [1:0] idx,
                             input logic [WORD_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = is_write;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {16'b0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (is_write) begin
         sb.set_register(idx, value);
      end else if (csr_prdata !== {16'b0, sb.register_value(idx)}) begin
         $error("register %0d: expected 0x%0h, got 0x%0h", idx,
                sb.register_value(idx), csr_prdata);
         sb.mismatches++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.expected_records.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic configure(input logic [WORD_W-1:0] delay, input logic [WORD_W-1:0] limit,
                            input logic [WORD_W-1:0] vmax);
      wait_idle();
      csr_access(1'b1, CSR_SAVE_DELAY, delay);
      csr_access(1'b1, CSR_COUNTER_LIMIT, limit);
      csr_access(1'b1, CSR_VALUE_MAX, vmax);
      csr_access(1'b0, CSR_SAVE_DELAY, '0);
      csr_access(1'b0, CSR_COUNTER_LIMIT, '0);
      csr_access(1'b0, CSR_VALUE_MAX, '0);
   endtask

   function automatic logic [WORD_W-1:0] rand_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 16'($urandom_range(0, 2047));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] rand_func();
      case ($urandom_range(0, 9))
         0, 1, 2: return FUNC_TICK;
         3:       return FUNC_SAVE;
         4:       return FUNC_CANCEL;
         5, 6:    return FUNC_READ;
         7:       return FUNC_SCAN;
         8:       return FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
         default: return FUNC_W'($urandom);
      endcase
   endfunction

   // mostly arm / wait / commit sequences, the rest single random beats
   task automatic run_phase(input logic [WORD_W-1:0] delay, input logic [WORD_W-1:0] limit,
                            input logic [WORD_W-1:0] vmax);
      int unsigned start;
      int unsigned ticks;
      configure(delay, limit, vmax);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         if ($urandom_range(0, 9) < 6) begin
            send_request(FUNC_SAVE, rand_limit(), rand_limit());
            ticks = $urandom_range(0, ((delay < 24) ? delay : 24) + 2);
            repeat (ticks) send_request(FUNC_TICK, rand_limit(), rand_limit());
            if ($urandom_range(0, 9) == 0)
               send_request(rand_func(), rand_limit(), rand_limit());
            send_request(FUNC_SAVE, rand_limit(), rand_limit());
            if ($urandom_range(0, 9) < 3)
               send_request(FUNC_READ, rand_limit(), rand_limit());
         end else begin
            send_request(rand_func(), rand_limit(), rand_limit());
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_TICK;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset registers: erased read, save that cannot write yet, cancel,
      // unknown codes, scan on an erased store
      send_request(FUNC_READ, '0, '0);
      send_request(FUNC_TICK, '1, '1);
      send_request(FUNC_SAVE, '1, '0);
      send_request(FUNC_SAVE, '1, '0);
      send_request(FUNC_CANCEL, '0, '1);
      send_request(FUNC_UNUSED_FIRST, '1, '1);
      send_request(FUNC_UNUSED_LAST, '0, '0);
      send_request(FUNC_SCAN, '0, '0);

      // zero delay: arming beat never writes, one tick later it does
      configure('0, '0, '1);
      send_request(FUNC_SAVE, '1, '0);
      send_request(FUNC_SAVE, '1, '0);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_SAVE, '1, '0);
      send_request(FUNC_READ, '0, '0);
      // raw limits kept, clamped on read
      configure('0, '0, '0);
      send_request(FUNC_READ, '0, '0);
      configure('0, '0, VALUE_MAX_RST);
      send_request(FUNC_SAVE, '0, '1);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_SAVE, '0, '1);
      send_request(FUNC_READ, '0, '0);
      // worn slot skipped, next slot erased
      send_request(FUNC_SCAN, '0, '0);
      send_request(FUNC_READ, '1, '1);
      send_request(FUNC_W'(FUNC_UNUSED_FIRST + 3'd1), '0, '0);
      // cancel drops the armed save, next save re-arms
      send_request(FUNC_SAVE, 16'h1234, 16'h8765);
      send_request(FUNC_CANCEL, '0, '0);
      send_request(FUNC_TICK, '0, '0);
      send_request(FUNC_SAVE, 16'h1234, 16'h8765);

      // wear every slot until the scan runs off the store end
      repeat (FILL_ROUNDS) begin
         send_request(FUNC_SCAN, rand_limit(), rand_limit());
         send_request(FUNC_SAVE, rand_limit(), rand_limit());
         send_request(FUNC_TICK, rand_limit(), rand_limit());
         send_request(FUNC_SAVE, rand_limit(), rand_limit());
      end
      send_request(FUNC_SCAN, '0, '0);

      // random phases over several register settings
      run_phase('0, 16'($urandom_range(0, 3)), '1);
      run_phase('1, '1, '0);
      run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(0, 10)), 16'($urandom));
      run_phase(16'($urandom_range(0, 30)), 16'($urandom_range(0, 4)), VALUE_MAX_RST);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d request beats, %0d result beats: %0d record writes, %0d reads,",
               items_sent, results_seen, sb.writes_seen, sb.reads_seen);
      $display("%0d scans of which %0d ran into the store end, %0d mismatches",
               sb.scans_seen, sb.overflows_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_records.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
